// ===== rtl/sqcs_pkg.sv =====
// Shared types and constants for the sparse query cluster scorer.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sqcs_pkg;

  // Default store sizes.
  localparam int DEF_MAX_TERMS    = 1024;
  localparam int DEF_MAX_POSTINGS = 4096;
  localparam int DEF_MAX_CLUSTERS = 256;

  // Fixed field widths.
  localparam int ACT_W   = 3;
  localparam int IDX_W   = 12;
  localparam int TERM_W  = 16;
  localparam int BND_W   = 13;
  localparam int CID_W   = 8;
  localparam int AMT_W   = 16;
  localparam int SCORE_W = 48;
  localparam int PROD_W  = 2 * AMT_W;
  localparam int CCNT_W  = 9;
  localparam int TCNT_W  = 11;
  localparam int FMT_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 11;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Action codes on the input word.
  localparam logic [ACT_W-1:0] ACT_LOAD_DIR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_POST = 3'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_CLUSTERS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TERMS    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FORMAT   = 2'd2;

  // Value formats; anything at or above FMT_U8 uses the low byte.
  localparam logic [FMT_W-1:0] FMT_Q412 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_U16  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_U8   = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD_DIR, OP_LOAD_POST, OP_QUERY, OP_CLEAR, OP_READ
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_CHK, S_BHI, S_PRD, S_SRD, S_MUL, S_ACC, S_RDS
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  entry_index;
    logic [TERM_W-1:0] term_id;
    logic [BND_W-1:0]  bound;
    logic [CID_W-1:0]  cluster_id;
    logic [AMT_W-1:0]  amount;
    logic              last_term;
  } item_t;

  typedef struct packed {
    logic [CCNT_W-1:0] cluster_count;
    logic [TCNT_W-1:0] term_count;
    logic [FMT_W-1:0]  value_format;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/sqcs_front.sv =====
// Front end: takes input words, decodes the action and queues them.
// Depends on sqcs_pkg.
`default_nettype none
module sqcs_front import sqcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [TERM_W-1:0] in_term_id,
  input  wire logic [BND_W-1:0]  in_bound,
  input  wire logic [CID_W-1:0]  in_cluster_id,
  input  wire logic [AMT_W-1:0]  in_amount,
  input  wire logic              in_last_term,
  input  wire logic              q_pop,
  output logic                   q_valid,
  output item_t                  q_item
);

  item_t       slot_r [2];
  logic        wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;
  item_t       dec;

  always_comb begin
    unique case (in_action)
      ACT_LOAD_DIR:  dec.op = OP_LOAD_DIR;
      ACT_LOAD_POST: dec.op = OP_LOAD_POST;
      ACT_QUERY:     dec.op = OP_QUERY;
      ACT_CLEAR:     dec.op = OP_CLEAR;
      ACT_READ:      dec.op = OP_READ;
      default:       dec.op = OP_NONE;
    endcase
    dec.entry_index = in_entry_index;
    dec.term_id     = in_term_id;
    dec.bound       = in_bound;
    dec.cluster_id  = in_cluster_id;
    dec.amount      = in_amount;
    dec.last_term   = in_last_term;
  end

  assign busy    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rptr_r];
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sqcs_back.sv =====
// Back end: executes queued words against the directory, posting and
// score memories. Depends on sqcs_pkg.
`default_nettype none
module sqcs_back import sqcs_pkg::*; #(
  parameter int MAX_TERMS    = DEF_MAX_TERMS,
  parameter int MAX_POSTINGS = DEF_MAX_POSTINGS,
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  input  wire logic                q_valid,
  input  wire item_t               q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  output logic [SCORE_W-1:0]       out_score_out,
  output logic                     out_term_found,
  output logic                     out_query_done
);

  localparam int TAW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int NTW = $clog2(MAX_TERMS + 1);
  localparam int PAW = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
  localparam int CAW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int NCW = $clog2(MAX_CLUSTERS + 1);

  // Memories.
  logic [TERM_W-1:0]        term_mem [MAX_TERMS];
  logic [BND_W-1:0]         bnd_mem  [MAX_TERMS + 1];
  logic [CID_W+AMT_W-1:0]   post_mem [MAX_POSTINGS];
  logic [SCORE_W-1:0]       sc_mem   [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0]  sc_vld_r, sc_vld_nxt;

  logic [TERM_W-1:0]       term_q;
  logic [BND_W-1:0]        bnd_q;
  logic [CID_W+AMT_W-1:0]  post_q;
  logic [SCORE_W-1:0]      sc_q;
  logic                    sc_vq;

  logic [TAW-1:0]          term_raddr, term_waddr;
  logic                    term_we;
  logic [NTW-1:0]          bnd_raddr, bnd_waddr;
  logic                    bnd_we;
  logic [PAW-1:0]          post_raddr, post_waddr;
  logic                    post_we;
  logic [CAW-1:0]          sc_raddr, sc_waddr;
  logic                    sc_we;
  logic [SCORE_W-1:0]      sc_wdata;

  state_t                  state_r, state_nxt;
  logic [TERM_W-1:0]       key_r, key_nxt;
  logic [AMT_W-1:0]        wgt_r, wgt_nxt;
  logic                    last_r, last_nxt;
  logic [NTW-1:0]          lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [BND_W-1:0]        j_r, j_nxt, end_r, end_nxt;
  logic [CAW-1:0]          c_r, c_nxt;
  logic [AMT_W-1:0]        v_r, v_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [SCORE_W-1:0]      old_r, old_nxt;

  logic                    ov_nxt, ov_r;
  logic [SCORE_W-1:0]      os_nxt, os_r;
  logic                    of_nxt, of_r, od_nxt, od_r;

  logic [NCW-1:0]          nc;
  logic [NTW-1:0]          nt;
  logic                    narrow;
  logic [NTW-1:0]          mid;
  logic [CID_W-1:0]        pc;
  logic [AMT_W-1:0]        pv;
  logic [SCORE_W:0]        sum;

  assign nc = (32'(cfg.cluster_count) > 32'(MAX_CLUSTERS)) ? NCW'(MAX_CLUSTERS)
                                                          : NCW'(cfg.cluster_count);
  assign nt = (32'(cfg.term_count) > 32'(MAX_TERMS)) ? NTW'(MAX_TERMS)
                                                     : NTW'(cfg.term_count);
  assign narrow = (cfg.value_format >= FMT_U8);
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign pc  = post_q[CID_W+AMT_W-1:AMT_W];
  assign pv  = narrow ? {8'd0, post_q[7:0]} : post_q[AMT_W-1:0];
  assign sum = {1'b0, old_r} + (SCORE_W+1)'(prod_r);

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    wgt_nxt    = wgt_r;
    last_nxt   = last_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    j_nxt      = j_r;
    end_nxt    = end_r;
    c_nxt      = c_r;
    v_nxt      = v_r;
    prod_nxt   = prod_r;
    old_nxt    = old_r;
    sc_vld_nxt = sc_vld_r;
    q_pop      = 1'b0;
    ov_nxt     = 1'b0;
    os_nxt     = '0;
    of_nxt     = 1'b0;
    od_nxt     = 1'b0;
    term_raddr = '0;
    term_waddr = TAW'(q_item.entry_index);
    term_we    = 1'b0;
    bnd_raddr  = '0;
    bnd_waddr  = NTW'(q_item.entry_index);
    bnd_we     = 1'b0;
    post_raddr = '0;
    post_waddr = PAW'(q_item.entry_index);
    post_we    = 1'b0;
    sc_raddr   = CAW'(q_item.entry_index);
    sc_waddr   = c_r;
    sc_we      = 1'b0;
    sc_wdata   = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_LOAD_DIR: begin
              term_we = (32'(q_item.entry_index) < 32'(MAX_TERMS));
              bnd_we  = (32'(q_item.entry_index) <= 32'(MAX_TERMS));
              ov_nxt  = 1'b1;
            end
            OP_LOAD_POST: begin
              post_we = (32'(q_item.entry_index) < 32'(MAX_POSTINGS));
              ov_nxt  = 1'b1;
            end
            OP_CLEAR: begin
              sc_vld_nxt = '0;
              ov_nxt     = 1'b1;
            end
            OP_READ: begin
              if (32'(q_item.entry_index) < 32'(nc)) begin
                state_nxt = S_RDS;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              key_nxt  = q_item.term_id;
              wgt_nxt  = narrow ? {8'd0, q_item.amount[7:0]} : q_item.amount;
              last_nxt = q_item.last_term;
              lo_nxt   = '0;
              hi_nxt   = nt;
              if (nc == '0 || nt == '0) begin
                ov_nxt = 1'b1;
                od_nxt = q_item.last_term;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          term_raddr = TAW'(mid);
          mid_nxt    = mid;
          state_nxt  = S_SCMP;
        end else if (lo_r >= nt) begin
          ov_nxt    = 1'b1;
          od_nxt    = last_r;
          state_nxt = S_IDLE;
        end else begin
          term_raddr = TAW'(lo_r);
          bnd_raddr  = lo_r;
          state_nxt  = S_CHK;
        end
      end
      S_SCMP: begin
        if (term_q < key_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      S_CHK: begin
        if (term_q != key_r) begin
          ov_nxt    = 1'b1;
          od_nxt    = last_r;
          state_nxt = S_IDLE;
        end else begin
          j_nxt     = bnd_q;
          bnd_raddr = lo_r + 1'b1;
          state_nxt = S_BHI;
        end
      end
      S_BHI: begin
        end_nxt   = (32'(bnd_q) > 32'(MAX_POSTINGS)) ? BND_W'(MAX_POSTINGS) : bnd_q;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        if (j_r < end_r) begin
          post_raddr = PAW'(j_r);
          j_nxt      = j_r + 1'b1;
          state_nxt  = S_SRD;
        end else begin
          ov_nxt    = 1'b1;
          of_nxt    = 1'b1;
          od_nxt    = last_r;
          state_nxt = S_IDLE;
        end
      end
      S_SRD: begin
        if (32'(pc) >= 32'(nc)) begin
          state_nxt = S_PRD;
        end else begin
          c_nxt     = CAW'(pc);
          sc_raddr  = CAW'(pc);
          v_nxt     = pv;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(wgt_r) * PROD_W'(v_r);
        old_nxt   = sc_vq ? sc_q : '0;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sc_we = 1'b1;
        sc_vld_nxt[c_r] = 1'b1;
        state_nxt = S_PRD;
      end
      S_RDS: begin
        ov_nxt    = 1'b1;
        os_nxt    = sc_vq ? sc_q : '0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sc_vld_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sc_vld_r <= sc_vld_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    wgt_r  <= wgt_nxt;
    last_r <= last_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    j_r    <= j_nxt;
    end_r  <= end_nxt;
    c_r    <= c_nxt;
    v_r    <= v_nxt;
    prod_r <= prod_nxt;
    old_r  <= old_nxt;
    os_r   <= os_nxt;
    of_r   <= of_nxt;
    od_r   <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (term_we) begin
      term_mem[term_waddr] <= q_item.term_id;
    end
    term_q <= term_mem[term_raddr];
  end

  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem[bnd_waddr] <= q_item.bound;
    end
    bnd_q <= bnd_mem[bnd_raddr];
  end

  always_ff @(posedge clk) begin
    if (post_we) begin
      post_mem[post_waddr] <= {q_item.cluster_id, q_item.amount};
    end
    post_q <= post_mem[post_raddr];
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
    end
    sc_q  <= sc_mem[sc_raddr];
    sc_vq <= sc_vld_r[sc_raddr];
  end

  assign out_valid      = ov_r;
  assign out_score_out  = os_r;
  assign out_term_found = of_r;
  assign out_query_done = od_r;

endmodule
`default_nettype wire

// ===== rtl/sparse_query_cluster_scorer.sv =====
// Top level of the sparse query cluster scorer: configuration registers,
// front end queue and back end engine. Depends on sqcs_pkg, sqcs_front, sqcs_back.
`default_nettype none
// Words are taken when start is high and busy is low; every word gives one
// result, shown for one cycle with out_valid, in the order the words came,
// and the receiver cannot hold it off. A two-entry queue sits between the
// decoder and the engine, so busy only rises when two words wait. Loads,
// clears and unknown actions are done in the idle state; a score read also
// passes through a score memory read. Each result shows on the cycle after
// the engine is done with its word. A query term runs a binary search, each
// step a directory read and a compare, at most floor(log2(term_count))+1
// steps; then it fetches and checks the slot and its bounds, and for each
// posting in its range reads the posting and the score, multiplies and
// writes back with saturation, skipping postings whose cluster is out of
// range, and closes the walk. Cleared scores are tracked by one valid bit per
// cluster, so a clear is instant and there is no clearing pass after reset.
// Configuration must be written only while idle; the block does not enforce it.
module sparse_query_cluster_scorer import sqcs_pkg::*; #(
  parameter int MAX_TERMS    = DEF_MAX_TERMS,
  parameter int MAX_POSTINGS = DEF_MAX_POSTINGS,
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [TERM_W-1:0]  in_term_id,
  input  wire logic [BND_W-1:0]   in_bound,
  input  wire logic [CID_W-1:0]   in_cluster_id,
  input  wire logic [AMT_W-1:0]   in_amount,
  input  wire logic               in_last_term,
  output logic                    out_valid,
  output logic [SCORE_W-1:0]      out_score_out,
  output logic                    out_term_found,
  output logic                    out_query_done,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDAT_W-1:0]  cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_valid, q_pop;
  item_t q_item;

  // Configuration writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLUSTERS: cfg_nxt.cluster_count = cfg_data[CCNT_W-1:0];
        CFG_TERMS:    cfg_nxt.term_count    = cfg_data[TCNT_W-1:0];
        CFG_FORMAT:   cfg_nxt.value_format  = cfg_data[FMT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sqcs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_term_id     (in_term_id),
    .in_bound       (in_bound),
    .in_cluster_id  (in_cluster_id),
    .in_amount      (in_amount),
    .in_last_term   (in_last_term),
    .q_pop          (q_pop),
    .q_valid        (q_valid),
    .q_item         (q_item)
  );

  sqcs_back #(
    .MAX_TERMS    (MAX_TERMS),
    .MAX_POSTINGS (MAX_POSTINGS),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_score_out  (out_score_out),
    .out_term_found (out_term_found),
    .out_query_done (out_query_done)
  );

endmodule
`default_nettype wire

// ===== rtl/sqcs_checker.sv =====
// Port-level checks for the sparse query cluster scorer, bound to the top.
// Depends on sqcs_pkg and sparse_query_cluster_scorer.
`default_nettype none
module sqcs_checker import sqcs_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [SCORE_W-1:0] out_score_out,
  input wire logic               out_term_found,
  input wire logic               out_query_done,
  input wire logic               cfg_ready
);

  // Reset leaves no result pending and the queue empty.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy right after reset");

  // Busy can only rise after a word was taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted word");

  // A nonzero score comes only from a read, never with query flags.
  a_score_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_score_out != '0 |-> !out_term_found && !out_query_done)
    else $error("score reported alongside query flags");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind sparse_query_cluster_scorer sqcs_checker u_sqcs_checker (.*);
`default_nettype wire
